/* src/fdr_pkg.sv */
// Shared types, constants and helpers for the dirty rectangle unit.
`timescale 1ns / 1ps
`default_nettype none

package fdr_pkg;

    localparam int MAX_SIDE_DEF = 4096;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int PB_W         = 3;
    localparam int PIX_W        = 32;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PIXEL_BYTES  = 2'd2,
        CFG_BLANK_MODE   = 2'd3
    } cfg_index_t;

    // pixel size codes
    localparam logic [PB_W-1:0] PB_TWO   = 3'd2;
    localparam logic [PB_W-1:0] PB_THREE = 3'd3;
    localparam logic [PB_W-1:0] PB_FOUR  = 3'd4;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [PB_W-1:0]  RST_PIXEL_BYTES  = PB_TWO;
    localparam logic             RST_BLANK_MODE   = 1'b0;

    // one compared pixel pair on its way to the tracker
    typedef struct packed {
        logic valid;
        logic diff;
    } fdr_beat_t;

    // bytes compared; an unknown size compares nothing
    function automatic logic [PIX_W-1:0] pixel_mask(input logic [PB_W-1:0] pb);
        logic [PIX_W-1:0] m;
        unique case (pb)
            PB_TWO:   m = 32'h0000_FFFF;
            PB_THREE: m = 32'h00FF_FFFF;
            PB_FOUR:  m = 32'hFFFF_FFFF;
            default:  m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* src/fdr_pixel_stage.sv */
// Input register: takes a pixel pair and holds its masked difference flag.
`timescale 1ns / 1ps
`default_nettype none

module fdr_pixel_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [fdr_pkg::PB_W-1:0]  pixel_bytes,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [fdr_pkg::PIX_W-1:0] new_pixel,
    input  wire logic [fdr_pkg::PIX_W-1:0] shadow_pixel,
    output fdr_pkg::fdr_beat_t             beat,
    input  wire logic                      take
);
    import fdr_pkg::*;

    logic valid_reg, valid_next;
    logic diff_reg, diff_next;
    logic accept;

    // stage frees up in the same cycle the tracker consumes it
    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = accept || (valid_reg && !take);
        diff_next  = diff_reg;
        if (accept)
        begin
            diff_next = |((new_pixel ^ shadow_pixel) & pixel_mask(pixel_bytes));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign beat.valid = valid_reg;
    assign beat.diff  = diff_reg;

endmodule

`default_nettype wire

/* src/fdr_box_tracker.sv */
// Raster position, bounding box and result register.
`timescale 1ns / 1ps
`default_nettype none

module fdr_box_tracker #(
    parameter int COL_W  = 12,
    parameter int SIDE_W = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [SIDE_W-1:0]  eff_width,
    input  wire logic [SIDE_W-1:0]  eff_height,
    input  wire logic               blank,
    input  wire fdr_pkg::fdr_beat_t beat,
    output logic                    take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    changed,
    output logic [COL_W-1:0]        left,
    output logic [COL_W-1:0]        top,
    output logic [SIDE_W-1:0]       rect_width,
    output logic [SIDE_W-1:0]       rect_height
);
    import fdr_pkg::*;

    logic [COL_W-1:0] column_reg, column_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] min_col_reg, min_col_next;
    logic [COL_W-1:0] max_col_reg, max_col_next;
    logic [COL_W-1:0] min_row_reg, min_row_next;
    logic [COL_W-1:0] max_row_reg, max_row_next;
    logic             any_reg, any_next;
    logic             out_valid_reg, out_valid_next;
    logic             changed_reg, changed_next;
    logic [COL_W-1:0] left_reg, left_next;
    logic [COL_W-1:0] top_reg, top_next;
    logic [SIDE_W-1:0] rw_reg, rw_next;
    logic [SIDE_W-1:0] rh_reg, rh_next;

    logic last_col, last_row, frame_end, hit;
    logic [COL_W-1:0] min_col_upd, max_col_upd, min_row_upd, max_row_upd;
    logic             any_upd;

    assign last_col  = SIDE_W'(column_reg) >= (eff_width - SIDE_W'(1));
    assign last_row  = SIDE_W'(row_reg) >= (eff_height - SIDE_W'(1));
    assign frame_end = last_col && last_row;
    // a frame-end beat waits while the result register is still full
    assign take      = beat.valid && (!frame_end || !out_valid_reg || out_ready);
    assign hit       = take && beat.diff;

    always_comb
    begin
        min_col_upd = (hit && column_reg < min_col_reg) ? column_reg : min_col_reg;
        max_col_upd = (hit && column_reg > max_col_reg) ? column_reg : max_col_reg;
        min_row_upd = (hit && row_reg < min_row_reg) ? row_reg : min_row_reg;
        max_row_upd = (hit && row_reg > max_row_reg) ? row_reg : max_row_reg;
        any_upd     = any_reg || hit;

        column_next    = column_reg;
        row_next       = row_reg;
        min_col_next   = min_col_upd;
        max_col_next   = max_col_upd;
        min_row_next   = min_row_upd;
        max_row_next   = max_row_upd;
        any_next       = any_upd;
        out_valid_next = out_valid_reg && !out_ready;
        changed_next   = changed_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;

        if (take)
        begin
            if (!last_col)
            begin
                column_next = column_reg + COL_W'(1);
            end
            else
            begin
                column_next = '0;
                if (!last_row)
                begin
                    row_next = row_reg + COL_W'(1);
                end
                else
                begin
                    row_next       = '0;
                    out_valid_next = 1'b1;
                    priority if (blank)
                    begin
                        changed_next = 1'b1;
                        left_next    = '0;
                        top_next     = '0;
                        rw_next      = eff_width;
                        rh_next      = eff_height;
                    end
                    else if (any_upd)
                    begin
                        changed_next = 1'b1;
                        left_next    = min_col_upd;
                        top_next     = min_row_upd;
                        rw_next      = SIDE_W'(max_col_upd) - SIDE_W'(min_col_upd)
                                       + SIDE_W'(1);
                        rh_next      = SIDE_W'(max_row_upd) - SIDE_W'(min_row_upd)
                                       + SIDE_W'(1);
                    end
                    else
                    begin
                        changed_next = 1'b0;
                        left_next    = '0;
                        top_next     = '0;
                        rw_next      = '0;
                        rh_next      = '0;
                    end
                    min_col_next = '1;
                    max_col_next = '0;
                    min_row_next = '1;
                    max_row_next = '0;
                    any_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        changed_reg <= changed_next;
        left_reg    <= left_next;
        top_reg     <= top_next;
        rw_reg      <= rw_next;
        rh_reg      <= rh_next;
    end

    assign out_valid   = out_valid_reg;
    assign changed     = changed_reg;
    assign left        = left_reg;
    assign top         = top_reg;
    assign rect_width  = rw_reg;
    assign rect_height = rh_reg;

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        any_reg |-> (min_col_reg <= max_col_reg && min_row_reg <= max_row_reg))
        else $error("dirty box bounds crossed");

    a_frame_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && frame_end) |=> out_valid_reg)
        else $error("frame end gave no result");

    a_no_change_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !changed_reg) |-> (rw_reg == '0 && rh_reg == '0
            && left_reg == '0 && top_reg == '0))
        else $error("unchanged frame reported a rectangle");

    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last_col) |=> (column_reg == $past(column_reg) + COL_W'(1)))
        else $error("column did not advance");

endmodule

`default_nettype wire

/* src/framebuffer_dirty_rectangle_unit.sv */
// Top level of the framebuffer dirty rectangle unit.
//
// Streams pixel pairs (new framebuffer pixel, shadow pixel) in raster order and
// reports, once per frame, the smallest rectangle covering every differing pixel.
// Input channel: in_valid/in_ready with new_pixel and shadow_pixel; one beat per
// pixel, frame_width beats per row, frame_height rows per frame.
// Output channel: out_valid/out_ready with changed, left, top, rect_width and
// rect_height; exactly one beat per frame, also when nothing changed (changed=0,
// all else zero). With blank_mode set the whole frame is reported.
// Config: cfg_we/cfg_index/cfg_data, written with no wait; the user writes it
// only while idle, which the block does not enforce. Throughput: one pixel pair
// per cycle, except while a held result stalls the last pixel of a frame.
// The input register, then the bounding-box update, feed the result register.
// Back-pressure: a held result only stalls the last pixel of the next frame;
// every other beat keeps flowing. in_ready follows out_ready in that case.
// Reset: asynchronous, active low; restores the config defaults (640 x 480,
// 2-byte pixels, blank off), clears the position and an empty box.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_dirty_rectangle_unit #(
    parameter int  MAX_SIDE = fdr_pkg::MAX_SIDE_DEF,
    localparam int COL_W    = $clog2(MAX_SIDE),
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fdr_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fdr_pkg::PIX_W-1:0]     new_pixel,
    input  wire logic [fdr_pkg::PIX_W-1:0]     shadow_pixel,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               changed,
    output logic [COL_W-1:0]                   left,
    output logic [COL_W-1:0]                   top,
    output logic [SIDE_W-1:0]                  rect_width,
    output logic [SIDE_W-1:0]                  rect_height
);
    import fdr_pkg::*;

    // wide enough for both the raw register and the side limit
    localparam int LIM_W = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [PB_W-1:0]  pixel_bytes_reg, pixel_bytes_next;
    logic             blank_mode_reg, blank_mode_next;

    logic [LIM_W-1:0]  fw_ext, fh_ext;
    logic [SIDE_W-1:0] eff_width, eff_height;
    fdr_beat_t         beat;
    logic              take;

    // register file
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        pixel_bytes_next  = pixel_bytes_reg;
        blank_mode_next   = blank_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
                CFG_PIXEL_BYTES:  pixel_bytes_next  = cfg_data[PB_W-1:0];
                CFG_BLANK_MODE:   blank_mode_next   = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            pixel_bytes_reg  <= RST_PIXEL_BYTES;
            blank_mode_reg   <= RST_BLANK_MODE;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            pixel_bytes_reg  <= pixel_bytes_next;
            blank_mode_reg   <= blank_mode_next;
        end
    end

    // effective frame size: zero acts as one, saturate at MAX_SIDE
    assign fw_ext = LIM_W'(frame_width_reg);
    assign fh_ext = LIM_W'(frame_height_reg);

    always_comb
    begin
        priority if (fw_ext == '0)
            eff_width = SIDE_W'(1);
        else if (fw_ext > LIM_W'(MAX_SIDE))
            eff_width = SIDE_W'(MAX_SIDE);
        else
            eff_width = fw_ext[SIDE_W-1:0];

        priority if (fh_ext == '0)
            eff_height = SIDE_W'(1);
        else if (fh_ext > LIM_W'(MAX_SIDE))
            eff_height = SIDE_W'(MAX_SIDE);
        else
            eff_height = fh_ext[SIDE_W-1:0];
    end

    fdr_pixel_stage u_pixel_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_bytes  (pixel_bytes_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .new_pixel    (new_pixel),
        .shadow_pixel (shadow_pixel),
        .beat         (beat),
        .take         (take)
    );

    fdr_box_tracker #(
        .COL_W  (COL_W),
        .SIDE_W (SIDE_W)
    ) u_box_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .blank       (blank_mode_reg),
        .beat        (beat),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .changed     (changed),
        .left        (left),
        .top         (top),
        .rect_width  (rect_width),
        .rect_height (rect_height)
    );

endmodule

`default_nettype wire
